[design/sprqt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Spatial point range query table package
// Command and status codes used by the table; its port checker shares the status codes.
// ---------------------------------------------------------------------------
package sprqt_pkg;

  // Command codes carried by in_cmd.
  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_RECT   = 3'd3,
    CMD_CIRCLE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  // Status codes carried by out_status.
  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_MATCH    = 3'd3,
    ST_NOMATCH  = 3'd4
  } status_t;

  localparam int STAMP_BITS = 32;
  localparam int COUNT_BITS = 6;

endpackage
`default_nettype wire

[design/spatial_point_range_query_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Spatial point range query table
// Up to CAPACITY tagged points in insertion order, kept in one synchronous
// memory; remove, update and queries walk the stored entries one at a time.
// ---------------------------------------------------------------------------
// Insert, clear and unused codes go straight to the finish state, which emits the result.
// Remove and update read and evaluate each stored entry; an update stops at its hit.
// Rect query reads and evaluates each entry; a circle query adds the squaring and
// compare steps, and each match passes through the push state; one memory read port.
// One command is in flight at a time; in_stall stays high until it ends.
// Reset empties the table; the entry memory itself is not cleared.
module spatial_point_range_query_table #(
  parameter int CAPACITY   = 32,
  parameter int COORD_BITS = 24,
  parameter int ID_BITS    = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   in_cmd,
  input  wire logic [ID_BITS-1:0]           in_id,
  input  wire logic signed [COORD_BITS-1:0] in_pos_x,
  input  wire logic signed [COORD_BITS-1:0] in_pos_y,
  input  wire logic signed [COORD_BITS-1:0] in_pos_z,
  input  wire logic [31:0]                  in_stamp,
  input  wire logic signed [COORD_BITS-1:0] in_min_x,
  input  wire logic signed [COORD_BITS-1:0] in_max_x,
  input  wire logic signed [COORD_BITS-1:0] in_min_y,
  input  wire logic signed [COORD_BITS-1:0] in_max_y,
  input  wire logic [COORD_BITS-2:0]        in_radius,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        out_status,
  output logic [ID_BITS-1:0]                out_id,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic signed [COORD_BITS-1:0]      out_z,
  output logic [31:0]                       out_stamp,
  output logic [5:0]                        out_count,
  output logic                              out_last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DW = COORD_BITS + 1;
  localparam int SW = 2 * DW + 1;
  localparam int RW = 2 * (COORD_BITS - 1);

  typedef struct packed {
    logic [ID_BITS-1:0]           id;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [31:0]                  stamp;
  } entry_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_EV   = 8'b0000_0100,
    S_SQX  = 8'b0000_1000,
    S_SQY  = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_PUSH = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  // Absolute difference of two signed coordinates.
  function automatic logic [DW-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                             input logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] wj_r, wj_nxt;
  logic found_r, found_nxt;
  logic pend_v_r, pend_v_nxt;
  entry_t pend_r, pend_nxt;
  sprqt_pkg::status_t fin_st_r, fin_st_nxt;

  // Command held for the duration of the transaction.
  logic [2:0] cmd_r;
  entry_t key_r;
  logic signed [COORD_BITS-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [RW-1:0] r2_r;
  logic [2*DW-1:0] sqx_r, sqy_r;

  // Entry memory.
  entry_t mem [CAPACITY];
  entry_t rd_q;
  logic rd_en;
  logic we;
  logic [AW-1:0] waddr;
  entry_t wdata;

  // Output register.
  logic out_valid_r;
  sprqt_pkg::status_t out_status_r;
  entry_t out_ent_r;
  logic [CW-1:0] out_cnt_r;
  logic out_last_r;
  logic emit;
  logic emit_match;
  logic emit_last;
  entry_t emit_ent;
  sprqt_pkg::status_t emit_st;

  logic accept;
  logic slot_free;
  logic rect_hit;
  logic [SW-1:0] dist2;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  assign rect_hit = (rd_q.x >= min_x_r) && (rd_q.x <= max_x_r) &&
                    (rd_q.y >= min_y_r) && (rd_q.y <= max_y_r);
  assign dist2    = SW'(sqx_r) + SW'(sqy_r);

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[ptr_r[AW-1:0]];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    wj_nxt     = wj_r;
    found_nxt  = found_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    fin_st_nxt = fin_st_r;
    rd_en      = 1'b0;
    we         = 1'b0;
    waddr      = ptr_r[AW-1:0];
    wdata      = rd_q;
    emit       = 1'b0;
    emit_match = 1'b0;
    emit_last  = 1'b1;
    emit_ent   = pend_r;
    emit_st    = fin_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ptr_nxt    = '0;
          wj_nxt     = '0;
          found_nxt  = 1'b0;
          pend_v_nxt = 1'b0;
          fin_st_nxt = sprqt_pkg::ST_DONE;
          state_nxt  = S_FIN;
          case (in_cmd)
            sprqt_pkg::CMD_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                fin_st_nxt = sprqt_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = cnt_r[AW-1:0];
                wdata   = '{id: in_id, x: in_pos_x, y: in_pos_y, z: in_pos_z,
                            stamp: in_stamp};
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            sprqt_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            sprqt_pkg::CMD_REMOVE, sprqt_pkg::CMD_UPDATE,
            sprqt_pkg::CMD_RECT, sprqt_pkg::CMD_CIRCLE: begin
              state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (ptr_r == cnt_r) begin
          state_nxt = S_FIN;
          case (cmd_r)
            sprqt_pkg::CMD_REMOVE: begin
              cnt_nxt    = wj_r;
              fin_st_nxt = found_r ? sprqt_pkg::ST_DONE : sprqt_pkg::ST_NOTFOUND;
            end
            sprqt_pkg::CMD_UPDATE: fin_st_nxt = sprqt_pkg::ST_NOTFOUND;
            default:               fin_st_nxt = sprqt_pkg::ST_NOMATCH;
          endcase
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_RD;
        case (cmd_r)
          sprqt_pkg::CMD_REMOVE: begin
            if (rd_q.id == key_r.id) begin
              found_nxt = 1'b1;
            end else begin
              we     = 1'b1;
              waddr  = wj_r[AW-1:0];
              wj_nxt = wj_r + 1'b1;
            end
          end
          sprqt_pkg::CMD_UPDATE: begin
            if (rd_q.id == key_r.id) begin
              we          = 1'b1;
              wdata       = key_r;
              wdata.id    = rd_q.id;
              wdata.stamp = '0;
              state_nxt   = S_FIN;
            end
          end
          sprqt_pkg::CMD_RECT: begin
            if (rect_hit) begin
              state_nxt = S_PUSH;
            end
          end
          default: state_nxt = S_SQX;
        endcase
      end
      S_SQX: state_nxt = S_SQY;
      S_SQY: state_nxt = S_CMP;
      S_CMP: begin
        state_nxt = (dist2 <= SW'(r2_r)) ? S_PUSH : S_RD;
      end
      S_PUSH: begin
        // The previous match goes out once the next one is known.
        if (!pend_v_r) begin
          pend_v_nxt = 1'b1;
          pend_nxt   = rd_q;
          state_nxt  = S_RD;
        end else if (slot_free) begin
          emit       = 1'b1;
          emit_match = 1'b1;
          emit_last  = 1'b0;
          pend_nxt   = rd_q;
          state_nxt  = S_RD;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_match = pend_v_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (emit_match) begin
      emit_st = sprqt_pkg::ST_MATCH;
    end else begin
      emit_ent = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    wj_r     <= wj_nxt;
    found_r  <= found_nxt;
    pend_r   <= pend_nxt;
    fin_st_r <= fin_st_nxt;
    if (accept) begin
      cmd_r   <= in_cmd;
      key_r   <= '{id: in_id, x: in_pos_x, y: in_pos_y, z: in_pos_z, stamp: in_stamp};
      min_x_r <= in_min_x;
      max_x_r <= in_max_x;
      min_y_r <= in_min_y;
      max_y_r <= in_max_y;
      r2_r    <= RW'(in_radius) * RW'(in_radius);
    end
    if (state_r == S_SQX) begin
      sqx_r <= abs_diff(rd_q.x, key_r.x) * abs_diff(rd_q.x, key_r.x);
    end
    if (state_r == S_SQY) begin
      sqy_r <= abs_diff(rd_q.y, key_r.y) * abs_diff(rd_q.y, key_r.y);
    end
    if (emit) begin
      out_status_r <= emit_st;
      out_ent_r    <= emit_ent;
      out_cnt_r    <= cnt_r;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_ent_r.id;
  assign out_x      = out_ent_r.x;
  assign out_y      = out_ent_r.y;
  assign out_z      = out_ent_r.z;
  assign out_stamp  = out_ent_r.stamp;
  assign out_count  = 6'(out_cnt_r);
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

[design/sprqt_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Spatial point range query table port checker
// Watches the ports of the table over time and is bound into every table instance.
// ---------------------------------------------------------------------------
module sprqt_chk #(
  parameter int CAPACITY   = 32,
  parameter int COORD_BITS = 24,
  parameter int ID_BITS    = 32
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [2:0]            out_status,
  input wire logic [ID_BITS-1:0]    out_id,
  input wire logic [COORD_BITS-1:0] out_x,
  input wire logic [5:0]            out_count,
  input wire logic                  out_last
);

  // A stalled result transaction holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_id))
    else $error("stalled result changed");

  // Only a match carries entry data.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sprqt_pkg::ST_MATCH |-> out_id == '0 && out_x == '0)
    else $error("non-match result carries entry data");

  // Every status other than a match closes its command.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sprqt_pkg::ST_MATCH |-> out_last)
    else $error("non-match result not last");

  // A command still has results to come, so no new command is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken during a query");

  // The table never reports a count above its capacity.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 7'(out_count) <= 7'(CAPACITY))
    else $error("count above capacity");

endmodule

bind spatial_point_range_query_table sprqt_chk #(
  .CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)
) u_sprqt_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_status(out_status), .out_id(out_id), .out_x(out_x),
  .out_count(out_count), .out_last(out_last)
);
`default_nettype wire
